// File: rtl/nhhl_pkg.sv
// ----------------------------------------------------------------------------
// nhhl_pkg: shared definitions for the name hash / hex literal block
// Character codes, counter limits, the hex digit decoder and the ELF hash step.
// ----------------------------------------------------------------------------
package nhhl_pkg;

    localparam int unsigned HASH_W   = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COUNT_W  = 4;

    localparam logic [COUNT_W-1:0] COUNT_SATURATE = 4'd9;

    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30; // '0'
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39; // '9'
    localparam logic [BYTE_W-1:0] CHAR_LC_A  = 8'h61; // 'a'
    localparam logic [BYTE_W-1:0] CHAR_LC_F  = 8'h66; // 'f'
    localparam logic [BYTE_W-1:0] CHAR_UC_A  = 8'h41; // 'A'
    localparam logic [BYTE_W-1:0] CHAR_UC_F  = 8'h46; // 'F'

    // Hex value of a character; anything that is not a hex digit reads as zero.
    function automatic logic [3:0] hex_digit(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] d;
        d = '0;
        if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            d = b - CHAR_ZERO;
        end else if (b >= CHAR_LC_A && b <= CHAR_LC_F) begin
            d = b - CHAR_LC_A + 8'd10;
        end else if (b >= CHAR_UC_A && b <= CHAR_UC_F) begin
            d = b - CHAR_UC_A + 8'd10;
        end
        return d[3:0];
    endfunction

    // One step of the ELF hash: shift in the byte, fold the top nibble into
    // bits 7:4 and clear it.
    function automatic logic [HASH_W-1:0] elf_step(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] b);
        logic [HASH_W-1:0] s;
        s = {h[HASH_W-5:0], 4'h0} + {{(HASH_W-BYTE_W){1'b0}}, b};
        return {4'h0, s[27:8], s[7:4] ^ s[31:28], s[3:0]};
    endfunction

endpackage

// File: rtl/name_hash_or_hex_literal.sv
// ----------------------------------------------------------------------------
// name_hash_or_hex_literal: ELF name hash or eight-digit hex literal
// Hashes a name one byte per item and gives one result on the last byte.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; the input register holds while a finished
// result waits in the output register and the next byte also ends a name.
// Reset (i_rst_n low, synchronous): clears name state, both valid flags and
// the literal base word.
module name_hash_or_hex_literal
    import nhhl_pkg::*;
#(
    parameter int unsigned LITERAL_DIGITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_wr_en,
    input  logic [HASH_W-1:0]    i_cfg_wr_data,   // literal_base_word
    // byte stream in
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [BYTE_W-1:0]    s_axis_tdata,    // [7:0] name_byte
    input  logic                 s_axis_tlast,    // last_byte
    // result stream out
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [HASH_W-1:0]    m_axis_tdata,    // [31:0] hash_value
    output logic                 m_axis_tuser     // [0] was_literal
);

    localparam logic [COUNT_W-1:0] LIT_CNT = COUNT_W'(LITERAL_DIGITS);

    logic [HASH_W-1:0]   r_base;

    // input register
    logic                r_in_valid;
    logic [BYTE_W-1:0]   r_in_byte;
    logic                r_in_last;

    // name state
    logic [HASH_W-1:0]   r_hash,  n_hash;
    logic [HASH_W-1:0]   r_acc,   n_acc;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_first0, n_first0;

    // result register
    logic                r_out_valid;
    logic [HASH_W-1:0]   r_out_hash, n_out_hash;
    logic                r_out_lit,  n_out_lit;

    logic                out_free;
    logic                adv;
    logic                in_acc;

    assign out_free      = !r_out_valid || m_axis_tready;
    // a byte that does not end a name never needs the output register
    assign adv           = r_in_valid && (!r_in_last || out_free);
    assign s_axis_tready = !r_in_valid || adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_hash   = elf_step(r_hash, r_in_byte);
        n_acc    = {r_acc[HASH_W-5:0], hex_digit(r_in_byte)};
        n_first0 = (r_count == '0) ? (r_in_byte == CHAR_ZERO) : r_first0;
        n_count  = (r_count < COUNT_SATURATE) ? r_count + 1'b1 : r_count;

        n_out_lit  = n_first0 && (n_count == LIT_CNT);
        n_out_hash = n_out_lit ? (n_acc | r_base) : n_hash;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_wr_en) begin
            r_base <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash   <= '0;
            r_acc    <= '0;
            r_count  <= '0;
            r_first0 <= 1'b0;
        end else if (adv) begin
            if (r_in_last) begin
                // name done: return to the empty-name state
                r_hash   <= '0;
                r_acc    <= '0;
                r_count  <= '0;
                r_first0 <= 1'b0;
            end else begin
                r_hash   <= n_hash;
                r_acc    <= n_acc;
                r_count  <= n_count;
                r_first0 <= n_first0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_last) begin
            r_out_hash <= n_out_hash;
            r_out_lit  <= n_out_lit;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_hash;
    assign m_axis_tuser  = r_out_lit;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_SATURATE)
        else $error("char count beyond saturation");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in_last |=> r_count == '0 && r_hash == '0 && !r_first0)
        else $error("name state not cleared after last byte");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && r_in_last && r_out_valid && !m_axis_tready)
        else $error("input stalled without a pending result");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(adv && r_in_last))
        else $error("result without a last byte");

endmodule

// File: dv/tb_name_hash_or_hex_literal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_name_hash_or_hex_literal: self-checking bench for the name hash block
// Streams names one byte per item, predicts the ELF hash or the eight-digit
// hex literal for every finished name, and checks each result in order.
// A short directed table comes first, then random names under several
// literal base words and several idle patterns on both streams.
// ----------------------------------------------------------------------------
module tb_name_hash_or_hex_literal;
    import nhhl_pkg::*;

    localparam int unsigned LITERAL_DIGITS = 8;
    localparam int unsigned PHASE_BYTES    = 310;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned LIMIT_CYCLES   = 400000;

    typedef struct packed {
        logic [HASH_W-1:0] hash_value;
        logic              was_literal;
    } t_name_result;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              typed;
        logic [HASH_W-1:0] hash_value;
        logic              was_literal;
    } t_name_row;

    logic                 i_clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [HASH_W-1:0]    cfg_wr_data = '0;
    logic                 s_valid = 1'b0;
    logic [BYTE_W-1:0]    s_data = '0;
    logic                 s_last = 1'b0;
    logic                 m_ready = 1'b0;
    logic                 s_axis_tready;
    logic                 m_axis_tvalid;
    logic [HASH_W-1:0]    m_axis_tdata;
    logic                 m_axis_tuser;

    // predictor state
    logic [HASH_W-1:0]    elf_acc = '0;
    logic [HASH_W-1:0]    digit_acc = '0;
    logic [COUNT_W-1:0]   name_len = '0;
    logic                 lead_zero = 1'b0;
    logic [HASH_W-1:0]    base_word = '0;

    t_name_result         pending_results[$];
    int unsigned          mismatches = 0;
    int unsigned          cycles = 0;
    int unsigned          send_idle_pct = 0;
    int unsigned          recv_idle_pct = 0;

    // "0FfFf9aA" is a literal, "0zG/:`@g" a literal of non-digits after '0'
    t_name_row directed_rows [21] = '{
        '{8'h00, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
        '{8'hFF, 1'b1, 1'b1, 32'h0000_00FF, 1'b0},
        '{8'h30, 1'b1, 1'b1, 32'h0000_0030, 1'b0},
        '{8'h30, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'h46, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'h66, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'h46, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'h66, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'h39, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'h61, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'h41, 1'b1, 1'b1, 32'h0FFF_F9AA, 1'b1},
        '{8'h30, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'h7A, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'h47, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'h2F, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'h3A, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'h60, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'h40, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'h67, 1'b1, 1'b1, 32'h0000_0000, 1'b1},
        '{8'h80, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'hFF, 1'b1, 1'b1, 32'h0000_08FF, 1'b0}
    };

    name_hash_or_hex_literal #(
        .LITERAL_DIGITS(LITERAL_DIGITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("name_hash_or_hex_literal: mismatch");
            $finish;
        end
    end

    function automatic logic [3:0] digit_value(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] d;
        d = '0;
        if (b inside {[CHAR_ZERO:CHAR_NINE]}) begin
            d = b - CHAR_ZERO;
        end else if (b inside {[CHAR_LC_A:CHAR_LC_F]}) begin
            d = b - CHAR_LC_A + 8'd10;
        end else if (b inside {[CHAR_UC_A:CHAR_UC_F]}) begin
            d = b - CHAR_UC_A + 8'd10;
        end
        return d[3:0];
    endfunction

    // Advance the name state by one byte; a last byte yields the result.
    task automatic absorb_name_byte(input logic [BYTE_W-1:0] b, input logic last,
                                    output logic done, output t_name_result res);
        logic [HASH_W-1:0] top;
        if (name_len == 0) begin
            lead_zero = (b == CHAR_ZERO);
        end
        elf_acc = (elf_acc << 4) + HASH_W'(b);
        top = elf_acc & 32'hF000_0000;
        elf_acc = elf_acc ^ (top | (top >> 24));
        digit_acc = (digit_acc << 4) | HASH_W'(digit_value(b));
        if (name_len < COUNT_SATURATE) begin
            name_len = name_len + 1'b1;
        end
        done = last;
        res = '0;
        if (last) begin
            if (lead_zero && name_len == COUNT_W'(LITERAL_DIGITS)) begin
                res.hash_value  = digit_acc | base_word;
                res.was_literal = 1'b1;
            end else begin
                res.hash_value  = elf_acc;
                res.was_literal = 1'b0;
            end
            elf_acc   = '0;
            digit_acc = '0;
            name_len  = '0;
            lead_zero = 1'b0;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last,
                             input logic use_typed, input t_name_result typed_res);
        logic         done;
        t_name_result res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        absorb_name_byte(b, last, done, res);
        if (done) begin
            pending_results.push_back(use_typed ? typed_res : res);
        end
        @(negedge i_clk);
    endtask

    task automatic settle_results();
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_base_word(input logic [HASH_W-1:0] value);
        s_valid <= 1'b0;
        settle_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        base_word = value;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [BYTE_W-1:0] rand_hex_char();
        int unsigned d;
        d = $urandom_range(0, 15);
        if (d < 10) begin
            return CHAR_ZERO + BYTE_W'(d);
        end
        return ($urandom_range(0, 1) ? CHAR_UC_A : CHAR_LC_A) + BYTE_W'(d - 10);
    endfunction

    // Mostly literal-shaped names, mixed at random with near misses and raw noise names.
    task automatic run_random_names(input int unsigned byte_budget);
        int unsigned       sent;
        int unsigned       kind;
        int unsigned       len;
        logic [BYTE_W-1:0] b;
        logic              lead_is_zero;
        sent = 0;
        while (sent < byte_budget) begin
            kind = $urandom_range(0, 9);
            lead_is_zero = 1'b1;
            if (kind < 5) begin
                len = LITERAL_DIGITS;
            end else if (kind < 7) begin
                case ($urandom_range(0, 2))
                    0: len = LITERAL_DIGITS - 1;
                    1: len = LITERAL_DIGITS + $urandom_range(1, 4);
                    default: begin
                        len = LITERAL_DIGITS;
                        lead_is_zero = 1'b0;
                    end
                endcase
            end else begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40)
                                                  : $urandom_range(1, 12);
            end
            for (int unsigned k = 0; k < len; k++) begin
                if (kind >= 7) begin
                    b = BYTE_W'($urandom_range(0, 255));
                end else if (k == 0) begin
                    b = lead_is_zero ? CHAR_ZERO : rand_hex_char();
                    if (!lead_is_zero && b == CHAR_ZERO) begin
                        b = CHAR_NINE;
                    end
                end else if ($urandom_range(0, 7) == 0) begin
                    b = BYTE_W'($urandom_range(0, 255));
                end else begin
                    b = rand_hex_char();
                end
                push_byte(b, k == len - 1, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // receiver stall pattern
    initial begin
        forever begin
            @(negedge i_clk);
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_name_result want;
        if (rst_n && m_axis_tvalid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: hash_value %08h was_literal %0d",
                       m_axis_tdata, m_axis_tuser);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.hash_value) begin
                    $error("hash_value: expected %08h, actual %08h",
                           want.hash_value, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tuser !== want.was_literal) begin
                    $error("was_literal: expected %0d, actual %0d",
                           want.was_literal, m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        t_name_result typed_res;
        repeat (10) @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 16;
        recv_idle_pct = 59;
        set_base_word(32'h0000_0000);
        foreach (directed_rows[i]) begin
            typed_res.hash_value  = directed_rows[i].hash_value;
            typed_res.was_literal = directed_rows[i].was_literal;
            push_byte(directed_rows[i].data, directed_rows[i].last,
                      directed_rows[i].typed, typed_res);
        end
        run_random_names(PHASE_BYTES);

        send_idle_pct = 59;
        recv_idle_pct = 16;
        set_base_word(32'hFFFF_FFFF);
        run_random_names(PHASE_BYTES);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_base_word($urandom());
        run_random_names(PHASE_BYTES);

        set_base_word(32'h8000_0001);
        run_random_names(PHASE_BYTES);

        s_valid <= 1'b0;
        settle_results();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("name_hash_or_hex_literal: match");
        end else begin
            $display("name_hash_or_hex_literal: mismatch");
        end
        $finish;
    end

endmodule
